[design/bdq_pkg.sv]
// Package for the bounded deque: sizes, operation and status codes,
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package bdq_pkg;

  // Ring size. It must be a power of two, so that ring positions wrap by truncation.
  localparam int CAPACITY    = 256;
  localparam int ENTRY_WIDTH = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int COUNT_W     = $clog2(CAPACITY + 1);

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 16;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_NONE        = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_HEAD = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_TAIL = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;  // latch the accepted request
    logic exec;       // update pointers and count, write the store
    logic rd_head;    // issue store read of the head slot
    logic rd_tail;    // issue store read of the tail slot
    logic rd_idx;     // issue store read of the indexed slot
    logic cap_head;   // capture read data as head value
    logic cap_tail;   // capture read data as tail value
    logic load_out;   // load the result register
  } bdq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;   // result register can take a new result this cycle
  } bdq_sts_t;

endpackage

`default_nettype wire

[design/bdq_if.sv]
// Handshake interfaces for the deque request and response channels.
// Depends on bdq_pkg.
`default_nettype none

interface bdq_req_if import bdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [VALUE_W-1:0]        entry_value;
  logic signed [INDEX_W-1:0] read_index;

  modport source (output valid, output operation, output entry_value,
                  output read_index, input ready);
  modport sink   (input valid, input operation, input entry_value,
                  input read_index, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  logic [VALUE_W-1:0]  head_value;
  logic [VALUE_W-1:0]  tail_value;
  logic [VALUE_W-1:0]  indexed_value;

  modport source (output valid, output status, output entry_count, output head_value,
                  output tail_value, output indexed_value, input ready);
  modport sink   (input valid, input status, input entry_count, input head_value,
                  input tail_value, input indexed_value, output ready);
endinterface

`default_nettype wire

[design/bdq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/bdq_ctrl.sv]
// Sequencer for the deque: accept, execute, three store reads, result load.
// Depends on bdq_pkg.
`default_nettype none

module bdq_ctrl import bdq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire bdq_sts_t sts_i,
  output bdq_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RDH  = 3'd2;
  localparam logic [2:0] S_RDT  = 3'd3;
  localparam logic [2:0] S_RDI  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RDH;
      end
      S_RDH: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_RDT;
      end
      S_RDT: begin
        cmd_o.rd_tail  = 1'b1;
        cmd_o.cap_head = 1'b1;
        state_d        = S_RDI;
      end
      S_RDI: begin
        cmd_o.rd_idx   = 1'b1;
        cmd_o.cap_tail = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        // indexed read data holds in the RAM output until the slot frees
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[design/bdq_dp.sv]
// Deque datapath: ring pointer, count, entry store, read capture, result register.
// Depends on bdq_pkg and bdq_ram.
`default_nettype none

module bdq_dp import bdq_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bdq_cmd_t                  cmd_i,
  output bdq_sts_t                       sts_o,
  input  wire logic [OP_W-1:0]           operation_i,
  input  wire logic [VALUE_W-1:0]        entry_value_i,
  input  wire logic signed [INDEX_W-1:0] read_index_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [STATUS_W-1:0]            status_o,
  output logic [COUNT_W-1:0]             entry_count_o,
  output logic [VALUE_W-1:0]             head_value_o,
  output logic [VALUE_W-1:0]             tail_value_o,
  output logic [VALUE_W-1:0]             indexed_value_o
);

  // latched request
  logic [OP_W-1:0]        op_q;
  logic [ENTRY_WIDTH-1:0] val_q;
  logic [INDEX_W-1:0]     idx_q;

  // deque state
  logic [ADDR_W-1:0]   head_q, head_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [STATUS_W-1:0] stat_q, stat_d;

  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic                   re;
  logic [ADDR_W-1:0]      raddr;
  logic [ENTRY_WIDTH-1:0] rdata;

  logic [ENTRY_WIDTH-1:0] head_val_q, tail_val_q;

  logic [ADDR_W-1:0]  last_off;
  logic [ADDR_W-1:0]  pos;
  logic [INDEX_W-1:0] count_ext;
  logic               is_full;
  logic               is_empty;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_stat_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic [VALUE_W-1:0]  out_head_q, out_tail_q, out_idx_q;

  assign is_full   = (count_q == COUNT_W'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign last_off  = ADDR_W'(count_q - COUNT_W'(1));
  assign count_ext = INDEX_W'(count_q);

  // clamp read position to 0..count-1
  always_comb begin
    if (idx_q[INDEX_W-1]) begin
      pos = '0;
    end else if (idx_q >= count_ext) begin
      pos = last_off;
    end else begin
      pos = idx_q[ADDR_W-1:0];
    end
  end

  // operation execute
  always_comb begin
    head_d = head_q;
    count_d = count_q;
    stat_d = STAT_OK;
    we = 1'b0;
    waddr = ADDR_W'(head_q + ADDR_W'(count_q));
    case (op_q)
      OP_INSERT_HEAD: begin
        if (is_full) begin
          stat_d = STAT_FULL;
        end else begin
          head_d  = head_q - ADDR_W'(1);
          waddr   = head_q - ADDR_W'(1);
          we      = cmd_i.exec;
          count_d = count_q + COUNT_W'(1);
        end
      end
      OP_INSERT_TAIL: begin
        if (is_full) begin
          stat_d = STAT_FULL;
        end else begin
          we      = cmd_i.exec;
          count_d = count_q + COUNT_W'(1);
        end
      end
      OP_REMOVE_HEAD: begin
        if (is_empty) begin
          stat_d = STAT_EMPTY;
        end else begin
          head_d  = head_q + ADDR_W'(1);
          count_d = count_q - COUNT_W'(1);
        end
      end
      OP_REMOVE_TAIL: begin
        if (is_empty) begin
          stat_d = STAT_EMPTY;
        end else begin
          count_d = count_q - COUNT_W'(1);
        end
      end
      default: begin
        stat_d = STAT_OK;
      end
    endcase
    if (count_d == '0 && stat_d == STAT_OK) begin
      stat_d = STAT_EMPTY;
    end
  end

  // read address select
  always_comb begin
    re = cmd_i.rd_head | cmd_i.rd_tail | cmd_i.rd_idx;
    if (cmd_i.rd_tail) begin
      raddr = head_q + last_off;
    end else if (cmd_i.rd_idx) begin
      raddr = head_q + pos;
    end else begin
      raddr = head_q;
    end
  end

  bdq_ram #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(val_q),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= operation_i;
      val_q <= ENTRY_WIDTH'(entry_value_i);
      idx_q <= read_index_i;
    end
    if (cmd_i.exec) begin
      stat_q <= stat_d;
    end
    if (cmd_i.cap_head) begin
      head_val_q <= rdata;
    end
    if (cmd_i.cap_tail) begin
      tail_val_q <= rdata;
    end
    if (cmd_i.load_out) begin
      out_stat_q  <= stat_q;
      out_count_q <= count_q;
      if (is_empty) begin
        out_head_q <= '0;
        out_tail_q <= '0;
        out_idx_q  <= '0;
      end else begin
        out_head_q <= VALUE_W'(head_val_q);
        out_tail_q <= VALUE_W'(tail_val_q);
        out_idx_q  <= VALUE_W'(rdata);
      end
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_stat_q;
  assign entry_count_o   = out_count_q;
  assign head_value_o    = out_head_q;
  assign tail_value_o    = out_tail_q;
  assign indexed_value_o = out_idx_q;

endmodule

`default_nettype wire

[design/bounded_deque_with_indexed_read.sv]
// Bounded double-ended queue of opaque entry words with an indexed read.
// Top level: joins controller and datapath; depends on bdq_pkg, bdq_if, bdq_ctrl, bdq_dp.
//
// Each request transfer carries one operation (none, insert head, insert tail,
// remove head, remove tail) and a signed read position; each one yields exactly
// one response transfer with status, count, head, tail and the entry at the
// position clamped to 0..count-1. Inserts into a full queue and removes from an
// empty one are refused (status full / empty) and change nothing; an empty queue
// reports status empty with all values zero. Unused operation codes act as none.
// Entries live in a 256-word ring addressed by a head pointer and a count; the
// store is not cleared at reset, and never needs to be since only held entries
// reach the response. Sequence: the request is taken, then pointers are updated
// and the store written, then the head, tail and indexed reads run in turn
// through the store's single read port, then the result register is loaded; a
// new request is taken only after that load. The response sits in the result
// register, so the next request is taken while it still waits; a held response
// stalls the sequencer only once the next result is ready to load.
`default_nettype none

module bounded_deque_with_indexed_read import bdq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bdq_req_if.sink   req_i,
  bdq_rsp_if.source rsp_o
);

  bdq_cmd_t cmd;
  bdq_sts_t sts;
  logic     in_ready;

  bdq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .in_ready_o(in_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bdq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (req_i.operation),
    .entry_value_i  (req_i.entry_value),
    .read_index_i   (req_i.read_index),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .entry_count_o  (rsp_o.entry_count),
    .head_value_o   (rsp_o.head_value),
    .tail_value_o   (rsp_o.tail_value),
    .indexed_value_o(rsp_o.indexed_value)
  );

  assign req_i.ready = in_ready;

  // one request in flight: a transfer is followed by a busy cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while the previous one is still executing");

  // count never beyond the ring size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.entry_count <= COUNT_W'(CAPACITY)))
    else $error("entry count beyond capacity");

  // an empty queue reports empty status and zero values
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.entry_count == '0) |->
      (rsp_o.status == STAT_EMPTY && rsp_o.head_value == '0 &&
       rsp_o.tail_value == '0 && rsp_o.indexed_value == '0))
    else $error("empty queue with non-zero values or wrong status");

  // a refused insert only happens on a full queue
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == STAT_FULL) |->
      (rsp_o.entry_count == COUNT_W'(CAPACITY)))
    else $error("full status with queue not full");

endmodule

`default_nettype wire
